// ----- hdl/mpq_pkg.sv -----
// Package for the sorted max-priority queue.
// Holds the sizes, function and status codes, and the controller/datapath types.
// No dependencies.
package mpq_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 6;
  localparam int STAT_W   = 2;

  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic execute;  // apply the latched operation and load the result register
  } mpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register empty or being taken this cycle
  } mpq_sts_t;

endpackage

// ----- hdl/mpq_if.sv -----
// Channel interfaces for the max-priority queue: operation items in, result items out.
// Depends on mpq_pkg.
interface mpq_in_if import mpq_pkg::*; ();
  logic valid;
  logic ready;
  logic func;
  val_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface mpq_out_if import mpq_pkg::*; ();
  logic              valid;
  logic              ready;
  val_t              max_value;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output max_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input max_value, input status, input occupancy,
                  output ready);
endinterface

// ----- hdl/max_priority_queue.sv -----
// Sorted max-priority queue of signed 32-bit values, top level.
// Channels: in_ch carries items {func, value}: func enqueue inserts value at its
//   sorted place, func dequeue removes the largest value. out_ch returns one
//   result item per input item: {max_value, status, occupancy}.
// Status: ok, dequeue on empty (max_value 0), enqueue dropped because full.
// Values sit in a row of CAPACITY cells kept in descending order; every cell
//   compares against the new value in parallel, so an operation is applied
//   whole in the execute state.
// Order: the accepted item is latched, then applied in the execute state once the
//   result register is free; the result register is loaded when it is applied.
// Rate: the two-state controller takes an item only in its idle state; ready
//   drops in the execute state, so no new item is taken until the last is applied.
// Stall: a result waits in the output register; the next item is still taken,
//   and its execute cycle waits until the held result has been taken.
// Reset (rst_n, synchronous, active low): queue empty, no result pending. Cell
//   contents are not cleared; cells past the count never affect a result.
// Depends on mpq_pkg, mpq_if, mpq_ctrl, mpq_dp.
module max_priority_queue import mpq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mpq_in_if.sink    in_ch,
  mpq_out_if.source out_ch
);

  mpq_cmd_t cmd;
  mpq_sts_t sts;
  logic     in_ready;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_ch.func),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_max_value (out_ch.max_value),
    .out_status    (out_ch.status),
    .out_occupancy (out_ch.occupancy)
  );

  assign in_ch.ready = in_ready;

`ifndef SYNTHESIS
  a_no_accept_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item not yet executed");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_ch.valid)
    else $error("execute did not produce a result");

  a_capture_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_EMPTY) |-> (out_ch.max_value == '0 &&
      out_ch.occupancy == '0))
    else $error("empty dequeue result malformed");
`endif

endmodule

// ----- hdl/mpq_ctrl.sv -----
// Controller for the max-priority queue: accepts one item, then runs it once the
// result register is free. Depends on mpq_pkg.
module mpq_ctrl import mpq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mpq_sts_t sts,
  output mpq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // wait here while an earlier result is still held
        if (sts.out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- hdl/mpq_dp.sv -----
// Datapath for the max-priority queue: row of sorted value cells, count and the
// result register. Depends on mpq_pkg.
module mpq_dp import mpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mpq_cmd_t          cmd,
  output mpq_sts_t          sts,
  input  logic              in_func,
  input  val_t              in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output val_t              out_max_value,
  output logic [STAT_W-1:0] out_status,
  output logic [OCC_W-1:0]  out_occupancy
);

  logic              func_r;
  val_t              value_r;
  val_t              cell_r [CAPACITY];
  val_t              cell_nxt [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  val_t              max_r, max_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]  occ_r;
  logic              full, empty;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // each cell holding a value strictly above the new one stays in place
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (cell_r[i] > value_r);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) cell_nxt[i] = cell_r[i];
    count_nxt  = count_r;
    max_nxt    = '0;
    status_nxt = ST_OK;
    if (func_r == FN_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        cell_nxt[0] = gt[0] ? cell_r[0] : value_r;
        for (int i = 1; i < CAPACITY; i++) begin
          if (gt[i])        cell_nxt[i] = cell_r[i];
          else if (gt[i-1]) cell_nxt[i] = value_r;
          else              cell_nxt[i] = cell_r[i-1];
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        max_nxt = cell_r[0];
        for (int i = 0; i < CAPACITY - 1; i++) cell_nxt[i] = cell_r[i+1];
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute)                  out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.execute) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      value_r <= in_value;
    end
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) cell_r[i] <= cell_nxt[i];
      max_r    <= max_nxt;
      status_r <= status_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_max_value  = max_r;
  assign out_status     = status_r;
  assign out_occupancy  = OCC_W'(occ_r);

endmodule
